FILE: hw/rtl/sliding_dft_16_bin_assert.svh
// Assertion macros shared by the sliding DFT RTL
`ifndef SLIDING_DFT_16_BIN_ASSERT_SVH
`define SLIDING_DFT_16_BIN_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDFT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdft assertion failed");
// next-cycle implication
`define SDFT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdft assertion failed");
`else
`define SDFT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SDFT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/sdft_pkg.sv
// Shared constants and controller/datapath types for the sliding DFT
`timescale 1ns / 1ps
package sdft_pkg;
  localparam int BINS_DEFAULT              = 16;
  localparam int TWIDDLE_FRAC_BITS_DEFAULT = 14;
  localparam int SAMPLE_W                  = 8;
  localparam int IDX_W                     = 4;
  localparam int BIN_W                     = 32;
  localparam int REC_W                     = 8;
  localparam int BIN_FRAC_BITS             = 12;

  typedef struct packed {
    logic start;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic drained;
  } status_t;
endpackage

FILE: hw/rtl/sdft_if.sv
// Request channel interfaces: sample input and bin result output
`timescale 1ns / 1ps
interface sdft_in_if;
  import sdft_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sdft_out_if;
  import sdft_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        bin_index;
  logic signed [BIN_W-1:0] bin_real;
  logic signed [BIN_W-1:0] bin_imag;
  logic                    last_bin;
  logic [REC_W-1:0]        reconstructed;
  modport source (output valid, output bin_index, output bin_real, output bin_imag,
                  output last_bin, output reconstructed, input ready);
  modport sink   (input valid, input bin_index, input bin_real, input bin_imag,
                  input last_bin, input reconstructed, output ready);
endinterface

FILE: hw/rtl/sdft_ctrl.sv
// Sequencer: accepts a sample, issues every bin, waits for the pipeline to drain
`timescale 1ns / 1ps
`include "sliding_dft_16_bin_assert.svh"
module sdft_ctrl #(
  parameter int BINS = sdft_pkg::BINS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sdft_pkg::status_t       status,
  output sdft_pkg::cmd_t          cmd,
  output logic [$clog2(BINS)-1:0] bin_k
);
  import sdft_pkg::*;

  localparam int K_W = $clog2(BINS);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} state_t;

  state_t         state;
  logic [K_W-1:0] k;

  assign in_ready  = (state == S_IDLE);
  assign cmd.start = in_valid && in_ready;
  assign cmd.issue = (state == S_ISSUE);
  assign bin_k     = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ISSUE;
            k     <= '0;
          end
        end
        S_ISSUE: begin
          if (status.adv) begin
            if (k == K_W'(BINS - 1)) state <= S_DRAIN;
            else k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          if (status.drained) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SDFT_ASSERT_IMP(a_ready_drained, clk, rst, in_ready, status.drained)
  `SDFT_ASSERT_NXT(a_stop_after_last, clk, rst, cmd.issue && status.adv && k == K_W'(BINS - 1), !cmd.issue)
  `SDFT_ASSERT_NXT(a_start_issues_zero, clk, rst, cmd.start, cmd.issue && k == '0)
endmodule

FILE: hw/rtl/sdft_datapath.sv
// Sample ring, bin stores, twiddle ROM and the bin update pipeline
`timescale 1ns / 1ps
`include "sliding_dft_16_bin_assert.svh"
module sdft_datapath #(
  parameter int BINS              = sdft_pkg::BINS_DEFAULT,
  parameter int TWIDDLE_FRAC_BITS = sdft_pkg::TWIDDLE_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdft_pkg::cmd_t                cmd,
  output sdft_pkg::status_t             status,
  input  logic [$clog2(BINS)-1:0]       bin_k,
  input  logic [sdft_pkg::SAMPLE_W-1:0] sample,
  sdft_out_if.source                    results
);
  import sdft_pkg::*;

  localparam int K_W      = $clog2(BINS);
  localparam int QN_W     = K_W + REC_W;
  localparam int TW_SHIFT = 30 - TWIDDLE_FRAC_BITS;
  localparam int STAGES   = 8;
  localparam int REC_SH   = QN_W + K_W;
  localparam int RECIP_W  = QN_W + 2;
  localparam int PROD_W   = QN_W + RECIP_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam longint unsigned SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam logic signed [64:0] ROUND_HALF = 65'sd1 <<< (TWIDDLE_FRAC_BITS - 1);
  localparam logic signed [64:0] BIN_MAX = 65'sd2147483647;
  localparam logic signed [64:0] BIN_MIN = -65'sd2147483648;
  localparam logic signed [63:0] REC_LIMIT = 64'(BINS) <<< (REC_W + BIN_FRAC_BITS);
  // ceil(2^REC_SH / BINS): exact quotient for any dividend below 2^QN_W
  localparam logic [RECIP_W-1:0] REC_RECIP =
    RECIP_W'(((64'd1 << REC_SH) + 64'(BINS) - 64'd1) / 64'(BINS));

  // cos or sin of 2*pi*idx/BINS: Q30 Taylor series, rounded to the twiddle format
  function automatic logic signed [BIN_W-1:0] tw_value(input int unsigned idx,
                                                        input logic want_sin);
    longint unsigned q, r, x, x2, tc, ts, m;
    longint sc, ss, val;
    int n;
    q  = (64'(idx) * 4) / BINS;
    r  = 64'(idx) * 4 - q * BINS;
    x  = (HALF_PI_Q30 * r) / BINS;
    x2 = (x * x) >> 30;
    tc = 64'd1 << 30;
    ts = x;
    sc = longint'(tc);
    ss = longint'(ts);
    for (n = 1; n <= 8; n++) begin
      tc = ((tc * x2) >> 30) / COS_DIV[n-1];
      ts = ((ts * x2) >> 30) / SIN_DIV[n-1];
      if (n[0]) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    case (q[1:0])
      2'd0:    val = want_sin ? ss : sc;
      2'd1:    val = want_sin ? sc : -ss;
      2'd2:    val = want_sin ? -ss : -sc;
      default: val = want_sin ? -sc : ss;
    endcase
    m = (val < 0) ? longint'(0) - val : val;
    if (TW_SHIFT > 0) m = (m + (64'd1 << (TW_SHIFT - 1))) >> TW_SHIFT;
    return (val < 0) ? BIN_W'(-m) : BIN_W'(m);
  endfunction

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [64:0] v);
    if (v > BIN_MAX) return {1'b0, {(BIN_W-1){1'b1}}};
    if (v < BIN_MIN) return {1'b1, {(BIN_W-1){1'b0}}};
    return v[BIN_W-1:0];
  endfunction

  // twiddle ROM
  logic signed [BIN_W-1:0] tw_cos [BINS];
  logic signed [BIN_W-1:0] tw_sin [BINS];

  for (genvar g = 0; g < BINS; g++) begin : g_rom
    localparam logic signed [BIN_W-1:0] COS_G = tw_value(g, 1'b0);
    localparam logic signed [BIN_W-1:0] SIN_G = tw_value(g, 1'b1);
    assign tw_cos[g] = COS_G;
    assign tw_sin[g] = SIN_G;
  end

  // control state
  logic [STAGES-1:0] stg_vld;
  logic              out_valid;
  logic              adv;
  logic [K_W-1:0]    ptr;
  logic              ring_wrapped;
  logic              bins_primed;

  // ring and bin stores
  logic [SAMPLE_W-1:0]     ring [BINS];
  logic [SAMPLE_W-1:0]     oldest_raw;
  logic [SAMPLE_W-1:0]     oldest;
  logic signed [SAMPLE_W:0] delta;
  logic signed [BIN_W-1:0] re_mem [BINS];
  logic signed [BIN_W-1:0] im_mem [BINS];

  // pipeline payload
  logic [K_W-1:0] k1, k2, k3, k4, k5, k6, k7, k8;
  logic           last1, last2, last3, last4, last5, last6, last7, last8;
  logic signed [BIN_W-1:0] re_rd, im_rd, c1, s1;
  logic signed [BIN_W-1:0] re2, im2, c2, s2;
  logic signed [2*BIN_W-1:0] prc3, pis3, prs3, pic3;
  logic signed [BIN_W-1:0] c3, s3;
  logic signed [BIN_W-1:0] nr4, ni4, c4, s4;
  logic signed [BIN_W-1:0] nr5, ni5, nr6, ni6, nr7, ni7, nr8, ni8;
  logic signed [2*BIN_W-1:0] pc5, ps5, term6, acc;
  logic                      neg8, big8;
  logic [QN_W-1:0]           qin8;

  // combinational pieces
  logic signed [BIN_W-1:0]                    re_old1, im_old1;
  logic signed [SAMPLE_W+BIN_FRAC_BITS:0]     dsh;
  logic signed [BIN_W+1:0]                    sum2;
  logic signed [64:0]                         d_re, d_im, d_t;
  logic [PROD_W-1:0]                          quo_prod;
  logic [REC_W-1:0]                           quo;
  logic [REC_W-1:0]                           rec;

  assign adv            = !out_valid || results.ready;
  assign status.adv     = adv;
  assign status.drained = (stg_vld == '0);

  assign oldest  = ring_wrapped ? oldest_raw : '0;
  assign re_old1 = bins_primed ? re_rd : '0;
  assign im_old1 = bins_primed ? im_rd : '0;
  assign dsh     = $signed({delta, {BIN_FRAC_BITS{1'b0}}});
  assign sum2    = (BIN_W+2)'(re_old1) + (BIN_W+2)'(dsh);
  assign d_re    = 65'(prc3) - 65'(pis3) + ROUND_HALF;
  assign d_im    = 65'(prs3) + 65'(pic3) + ROUND_HALF;
  assign d_t     = 65'(pc5) - 65'(ps5) + ROUND_HALF;

  // divide by BINS with a reciprocal multiply
  always_comb begin
    quo_prod = PROD_W'(qin8) * PROD_W'(REC_RECIP);
    quo      = REC_W'(quo_prod >> REC_SH);
    if (!last8 || neg8) rec = '0;
    else if (big8)      rec = {REC_W{1'b1}};
    else                rec = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld      <= '0;
      out_valid    <= 1'b0;
      ptr          <= '0;
      ring_wrapped <= 1'b0;
      bins_primed  <= 1'b0;
    end else begin
      if (adv) begin
        stg_vld   <= {stg_vld[STAGES-2:0], cmd.issue};
        out_valid <= stg_vld[STAGES-1];
        if (stg_vld[3] && last4) bins_primed <= 1'b1;
      end
      if (cmd.start) begin
        if (ptr == K_W'(BINS - 1)) begin
          ptr          <= '0;
          ring_wrapped <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    oldest_raw <= ring[ptr];
    if (cmd.start) begin
      ring[ptr] <= sample;
      delta     <= $signed({1'b0, sample}) - $signed({1'b0, oldest});
    end
  end

  // bin stores
  always_ff @(posedge clk) begin
    if (adv) begin
      re_rd <= re_mem[bin_k];
      im_rd <= im_mem[bin_k];
      if (stg_vld[3]) begin
        re_mem[k4] <= nr4;
        im_mem[k4] <= ni4;
      end
    end
  end

  // reconstruction accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) acc <= '0;
    else if (adv && stg_vld[5]) acc <= acc + term6;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1    <= bin_k;
      last1 <= (bin_k == K_W'(BINS - 1));
      c1    <= tw_cos[bin_k];
      s1    <= tw_sin[bin_k];

      k2    <= k1;
      last2 <= last1;
      re2   <= sat_bin(65'(sum2));
      im2   <= im_old1;
      c2    <= c1;
      s2    <= s1;

      k3    <= k2;
      last3 <= last2;
      prc3  <= re2 * c2;
      pis3  <= im2 * s2;
      prs3  <= re2 * s2;
      pic3  <= im2 * c2;
      c3    <= c2;
      s3    <= s2;

      k4    <= k3;
      last4 <= last3;
      nr4   <= sat_bin(d_re >>> TWIDDLE_FRAC_BITS);
      ni4   <= sat_bin(d_im >>> TWIDDLE_FRAC_BITS);
      c4    <= c3;
      s4    <= s3;

      k5    <= k4;
      last5 <= last4;
      nr5   <= nr4;
      ni5   <= ni4;
      pc5   <= nr4 * c4;
      ps5   <= ni4 * s4;

      k6    <= k5;
      last6 <= last5;
      nr6   <= nr5;
      ni6   <= ni5;
      term6 <= 64'(d_t >>> TWIDDLE_FRAC_BITS);

      k7    <= k6;
      last7 <= last6;
      nr7   <= nr6;
      ni7   <= ni6;

      k8    <= k7;
      last8 <= last7;
      nr8   <= nr7;
      ni8   <= ni7;
      neg8  <= acc[2*BIN_W-1];
      big8  <= (acc >= REC_LIMIT);
      qin8  <= acc[BIN_FRAC_BITS +: QN_W];

      results.bin_index     <= IDX_W'(k8);
      results.bin_real      <= nr8;
      results.bin_imag      <= ni8;
      results.last_bin      <= last8;
      results.reconstructed <= rec;
    end
  end

  assign results.valid = out_valid;

  `SDFT_ASSERT_IMP(a_last_index, clk, rst, results.valid && results.last_bin, results.bin_index == IDX_W'(BINS - 1))
  `SDFT_ASSERT_IMP(a_rec_only_last, clk, rst, results.valid && !results.last_bin, results.reconstructed == '0)
  `SDFT_ASSERT_IMP(a_start_empty, clk, rst, cmd.start, stg_vld == '0)
endmodule

FILE: hw/rtl/sliding_dft_16_bin.sv
// Top level of the sliding DFT: sequencer plus bin datapath
//
//   channel   role    payload
//   samples   sink    sample[7:0]
//   results   source  bin_index[3:0] bin_real[31:0] bin_imag[31:0] last_bin reconstructed[7:0]
//
// Each sample is accepted, then BINS bins are issued one per cycle, while results are taken,
// into the shared complex multiply pipeline; the sequencer then waits for that pipeline to
// drain and returns to idle before it accepts the next sample. A stalled results request
// freezes the whole pipeline. Reset is synchronous; ring and bin stores read as zero until
// first written.
`timescale 1ns / 1ps
module sliding_dft_16_bin #(
  parameter int BINS              = sdft_pkg::BINS_DEFAULT,
  parameter int TWIDDLE_FRAC_BITS = sdft_pkg::TWIDDLE_FRAC_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  sdft_in_if.sink    samples,
  sdft_out_if.source results
);
  import sdft_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic [$clog2(BINS)-1:0] bin_k;
  logic                    in_ready;

  assign samples.ready = in_ready;

  sdft_ctrl #(
    .BINS (BINS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .bin_k    (bin_k)
  );

  sdft_datapath #(
    .BINS              (BINS),
    .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .bin_k   (bin_k),
    .sample  (samples.sample),
    .results (results)
  );
endmodule

FILE: dv/sdft_bin_checker.sv
// Sliding DFT bin predictor and result comparator watching both request channels
`timescale 1ns / 1ps
module sdft_bin_checker (
  input  logic clk,
  input  logic rst,
  sdft_in_if   samples,
  sdft_out_if  results,
  output int   failures,
  output int   pending
);
  import sdft_pkg::*;

  localparam int NBINS   = BINS_DEFAULT;
  localparam int TW_FRAC = TWIDDLE_FRAC_BITS_DEFAULT;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic                    last;
    logic [REC_W-1:0]        rec;
  } bin_result_t;

  logic [SAMPLE_W-1:0] window [NBINS];
  logic [IDX_W-1:0]    oldest;
  int                  re_store [NBINS];
  int                  im_store [NBINS];
  int                  tw_cos [NBINS];
  int                  tw_sin [NBINS];
  bin_result_t         bins_due [$];
  int                  mismatch_count;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // half-up rounding of v / 2^TW_FRAC
  function automatic longint round_tw(longint v);
    return (v + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
  endfunction

  // Q30 to twiddle precision, ties away from zero
  function automatic int q30_to_twiddle(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
    return (v < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic void build_twiddles();
    longint unsigned x, x2, tc, ts;
    longint          sc, ss, rc, rs;
    int              q, r;
    for (int k = 0; k < NBINS; k++) begin
      q  = (4 * k) / NBINS;
      r  = 4 * k - q * NBINS;
      x  = (HALF_PI_Q30 * longint'(r)) / longint'(NBINS);
      x2 = (x * x) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      sc = longint'(tc);
      ss = longint'(ts);
      for (int n = 1; n <= 8; n++) begin
        tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      case (q % 4)
        0: begin rc = sc;  rs = ss;  end
        1: begin rc = -ss; rs = sc;  end
        2: begin rc = -sc; rs = -ss; end
        default: begin rc = ss; rs = -sc; end
      endcase
      tw_cos[k] = q30_to_twiddle(rc);
      tw_sin[k] = q30_to_twiddle(rs);
    end
  endfunction

  task automatic slide_and_rotate(input logic [SAMPLE_W-1:0] fresh);
    longint      delta, re, im, c, s, nr, ni, acc, rec;
    bin_result_t r;
    delta = longint'(fresh) - longint'(window[oldest]);
    window[oldest] = fresh;
    oldest = oldest + 1'b1;
    acc = 0;
    for (int k = 0; k < NBINS; k++) begin
      re = clip32(longint'(re_store[k]) + delta * (64'sd1 <<< BIN_FRAC_BITS));
      im = longint'(im_store[k]);
      c  = longint'(tw_cos[k]);
      s  = longint'(tw_sin[k]);
      nr = clip32(round_tw(re * c - im * s));
      ni = clip32(round_tw(re * s + im * c));
      re_store[k] = int'(nr);
      im_store[k] = int'(ni);
      acc = acc + round_tw(nr * c - ni * s);
      r.idx  = IDX_W'(k);
      r.re   = nr[BIN_W-1:0];
      r.im   = ni[BIN_W-1:0];
      r.last = (k == NBINS - 1);
      r.rec  = '0;
      if (r.last) begin
        if (acc < 0) rec = 0;
        else begin
          rec = acc / (longint'(NBINS) <<< BIN_FRAC_BITS);
          if (rec > 255) rec = 255;
        end
        r.rec = rec[REC_W-1:0];
      end
      bins_due.push_back(r);
    end
  endtask

  task automatic flag(input string field, input longint want, input longint got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  initial begin
    build_twiddles();
    mismatch_count = 0;
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      for (int k = 0; k < NBINS; k++) begin
        window[k]   = '0;
        re_store[k] = 0;
        im_store[k] = 0;
      end
      oldest = '0;
      bins_due.delete();
    end else begin
      if (samples.valid && samples.ready) slide_and_rotate(samples.sample);
      if (results.valid && results.ready) begin
        if (bins_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected bin, expected none, actual index %0d", $time,
                   results.bin_index);
        end else begin
          want = bins_due.pop_front();
          if (results.bin_index !== want.idx) flag("bin_index", want.idx, results.bin_index);
          if (results.bin_real !== want.re) flag("bin_real", want.re, results.bin_real);
          if (results.bin_imag !== want.im) flag("bin_imag", want.im, results.bin_imag);
          if (results.last_bin !== want.last) flag("last_bin", want.last, results.last_bin);
          if (results.reconstructed !== want.rec)
            flag("reconstructed", want.rec, results.reconstructed);
        end
      end
    end
    failures <= mismatch_count;
    pending  <= bins_due.size();
  end
endmodule

FILE: dv/testbench.sv
// Top of the sliding DFT testbench: clock, reset, sample stimulus, result stalls, verdict
`timescale 1ns / 1ps
module testbench;
  import sdft_pkg::*;

  localparam int RANDOM_SAMPLES = 430;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {PAT_UNIFORM, PAT_EXTREME, PAT_HOLD, PAT_RAMP} pattern_t;

  logic clk;
  logic rst;
  logic steady;
  int   failures;
  int   pending;
  int   cycle_count;

  sdft_in_if  samples_ch ();
  sdft_out_if results_ch ();

  sliding_dft_16_bin DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  sdft_bin_checker bin_check (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_ch),
    .results  (results_ch),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    results_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 14) begin
      gap = $urandom_range(1, 30);
      samples_ch.valid  <= 1'b0;
      samples_ch.sample <= SAMPLE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= value;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
  endtask

  initial begin
    pattern_t            pattern;
    int                  run_len;
    int                  sent;
    logic [SAMPLE_W-1:0] level;
    clk               = 1'b0;
    rst               = 1'b1;
    steady            = 1'b0;
    cycle_count       = 0;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    results_ch.ready  = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // full-swing steps both ways, mid and near-extreme levels, then a window of full scale and a step back to zero
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd128);
    send_sample(8'd1);
    send_sample(8'd254);
    repeat (16) send_sample(8'd255);
    send_sample(8'd0);

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      pattern = pattern_t'($urandom_range(0, 3));
      run_len = $urandom_range(8, 32);
      level   = SAMPLE_W'($urandom);
      steady  = (sent >= 180 && sent < 280);
      for (int i = 0; i < run_len; i++) begin
        case (pattern)
          PAT_UNIFORM: send_sample(SAMPLE_W'($urandom));
          PAT_EXTREME: send_sample($urandom_range(0, 1) ? 8'd255 : 8'd0);
          PAT_HOLD:    send_sample(level);
          default: begin
            send_sample(level);
            level = level + 8'd17;
          end
        endcase
        sent++;
      end
    end
    steady = 1'b0;

    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
